// ===== design/keypad_code_lock_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Keypad code lock controller - assertion macros
// Shared property wrappers, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define KLC_ASSERT(name, prop, text) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(text);

// Check that a condition is followed by an outcome in the next cycle.
`define KLC_ASSERT_NEXT(name, cond, outcome, text) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (outcome)) \
    else $error(text);

`endif

// ===== design/klc_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock controller - package
// Event kinds, action codes, key characters and the types passed between the
// front end, the bundle queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package klc_pkg;

  // Event kinds
  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_OPEN = 2'd1;
  localparam logic [1:0] KIND_LOCK = 2'd2;

  // Result actions
  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_CLEAR   = 3'd1,
    ACT_MESSAGE = 3'd2,
    ACT_OPEN    = 3'd3,
    ACT_LOCK    = 3'd4
  } action_e;

  // Key characters
  localparam logic [7:0] CH_NONE = 8'h00;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;

  localparam logic [31:0] RESET_CODE  = 32'h3433_3231;  // "1234", first key lowest
  localparam logic [8:0]  RESET_ANGLE = 9'd135;
  localparam logic [9:0]  MAX_ANGLE   = 10'd260;

  // Bundle layout
  localparam int MaxSlots   = 5;
  localparam int SlotW      = $clog2(MaxSlots + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  typedef struct packed {
    action_e    act;
    logic [7:0] ch;
    logic       msg;
  } slot_t;

  // All results of one event
  typedef struct packed {
    logic [SlotW-1:0]           cnt;
    slot_t [MaxSlots-1:0]       slot;
    logic                       ccw;
    logic [8:0]                 deg;
    logic                       door;
  } bundle_t;

  // One result word
  typedef struct packed {
    action_e    act;
    logic [7:0] ch;
    logic       msg;
    logic       dir;
    logic [8:0] deg;
    logic       door;
    logic       last;
  } word_t;

endpackage

`default_nettype wire

// ===== design/klc_front.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock controller - front end
// Accepts events, advances the lock state and packs the actions of each event
// into one bundle for the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keypad_code_lock_controller_assert.svh"

module klc_front import klc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] key_char_i,
  input  wire logic       full_i,
  output logic            q_push_o,
  output bundle_t         q_data_o
);

  localparam logic [2:0] MODE_WAIT     = 3'd0;
  localparam logic [2:0] MODE_PASSWORD = 3'd1;
  localparam logic [2:0] MODE_CHANGE   = 3'd2;
  localparam logic [2:0] MODE_DEGREE   = 3'd3;
  localparam logic [2:0] MODE_CLOCK    = 3'd4;

  logic [2:0]      mode_q, mode_d;
  logic [3:0]      kc_q, kc_d;
  logic [3:0][7:0] ent_q, ent_d;
  logic [3:0][7:0] stored_q, stored_d;
  logic [1:0][7:0] ad_q, ad_d;
  logic [8:0]      angle_q, angle_d;
  logic            ccw_q, ccw_d;
  logic            door_q, door_d;
  logic            accept;
  bundle_t         bnd;

  assign accept = push_i && !full_i;

  function automatic bundle_t add(bundle_t b, action_e a, logic [7:0] ch, logic msg);
    bundle_t r;
    r = b;
    if (r.cnt < SlotW'(MaxSlots)) begin
      r.slot[r.cnt].act = a;
      r.slot[r.cnt].ch  = (a == ACT_WRITE) ? ch : CH_NONE;
      r.slot[r.cnt].msg = (a == ACT_MESSAGE) ? msg : 1'b0;
      r.cnt             = r.cnt + SlotW'(1);
    end
    return r;
  endfunction

  always_comb begin
    logic [3:0] kn;
    logic       h_ok, t_ok, k_ok, ok;
    logic [9:0] v;
    mode_d   = mode_q;
    kc_d     = kc_q;
    ent_d    = ent_q;
    stored_d = stored_q;
    ad_d     = ad_q;
    angle_d  = angle_q;
    ccw_d    = ccw_q;
    door_d   = door_q;
    bnd      = '0;
    kn       = kc_q + 4'd1;
    h_ok     = (ad_q[0] >= CH_ZERO) && (ad_q[0] <= CH_NINE);
    t_ok     = (ad_q[1] >= CH_ZERO) && (ad_q[1] <= CH_NINE);
    k_ok     = (key_char_i >= CH_ZERO) && (key_char_i <= CH_NINE);
    v        = 10'(ad_q[0][3:0]) * 10'd100 + 10'(ad_q[1][3:0]) * 10'd10
             + 10'(key_char_i[3:0]);
    ok       = h_ok && t_ok && k_ok && (v <= MAX_ANGLE);
    unique case (kind_i)
      KIND_KEY: begin
        if (key_char_i != CH_NONE) begin
          unique case (mode_q)
            MODE_PASSWORD: begin
              kc_d = kn;
              bnd  = add(bnd, ACT_WRITE, CH_STAR, 1'b0);
              if (kn < 4'd4) ent_d[kn[1:0]] = key_char_i;
              if (kn >= 4'd3) begin
                if (ent_d == stored_q) begin
                  if (!door_q) bnd = add(bnd, ACT_OPEN, CH_NONE, 1'b0);
                  door_d = 1'b1;
                end
                bnd    = add(bnd, ACT_CLEAR, CH_NONE, 1'b0);
                kc_d   = 4'd0;
                mode_d = MODE_WAIT;
              end
            end
            MODE_CHANGE: begin
              bnd = add(bnd, ACT_WRITE, key_char_i, 1'b0);
              if (kc_q < 4'd4) ent_d[kc_q[1:0]] = key_char_i;
              kc_d = kn;
              if (kc_d == 4'd4) begin
                if (ent_d == stored_q) begin
                  bnd = add(bnd, ACT_WRITE, CH_HASH, 1'b0);
                end else begin
                  kc_d   = 4'd0;
                  mode_d = MODE_WAIT;
                  bnd    = add(bnd, ACT_CLEAR, CH_NONE, 1'b0);
                end
              end
              if (kc_d == 4'd5 && key_char_i != CH_D && key_char_i != CH_C)
                stored_d[0] = key_char_i;
              if (kc_d >= 4'd6 && kc_d <= 4'd8)
                stored_d[2'(kc_d - 4'd5)] = key_char_i;
              if (kc_d == 4'd5 && key_char_i == CH_D) mode_d = MODE_DEGREE;
              if (kc_d == 4'd5 && key_char_i == CH_C) mode_d = MODE_CLOCK;
              if (kc_d >= 4'd8) begin
                kc_d   = 4'd0;
                mode_d = MODE_WAIT;
                bnd    = add(bnd, ACT_CLEAR, CH_NONE, 1'b0);
              end
            end
            MODE_CLOCK: begin
              bnd = add(bnd, ACT_CLEAR, CH_NONE, 1'b0);
              if (key_char_i == CH_ONE) begin
                ccw_d = 1'b0;
                bnd   = add(bnd, ACT_MESSAGE, CH_NONE, 1'b0);
              end else if (key_char_i == CH_TWO) begin
                ccw_d = 1'b1;
                bnd   = add(bnd, ACT_MESSAGE, CH_NONE, 1'b1);
              end
              kc_d   = 4'd0;
              mode_d = MODE_WAIT;
            end
            MODE_DEGREE: begin
              bnd  = add(bnd, ACT_WRITE, key_char_i, 1'b0);
              kc_d = kn;
              if (kn == 4'd6) begin
                ad_d[0] = key_char_i;
              end else if (kn == 4'd7) begin
                ad_d[1] = key_char_i;
              end else if (kn >= 4'd8) begin
                bnd = add(bnd, ACT_CLEAR, CH_NONE, 1'b0);
                if (ok) begin
                  angle_d = v[8:0];
                  bnd     = add(bnd, ACT_WRITE, ad_q[0], 1'b0);
                  bnd     = add(bnd, ACT_WRITE, ad_q[1], 1'b0);
                  bnd     = add(bnd, ACT_WRITE, key_char_i, 1'b0);
                end
                kc_d   = 4'd0;
                mode_d = MODE_WAIT;
              end
            end
            default: begin
              if (kc_q == 4'd0) bnd = add(bnd, ACT_CLEAR, CH_NONE, 1'b0);
              if (key_char_i == CH_HASH) begin
                mode_d = MODE_CHANGE;
                bnd    = add(bnd, ACT_WRITE, CH_HASH, 1'b0);
              end else begin
                if (kc_q < 4'd4) ent_d[kc_q[1:0]] = key_char_i;
                bnd    = add(bnd, ACT_WRITE, CH_STAR, 1'b0);
                mode_d = MODE_PASSWORD;
              end
            end
          endcase
        end
      end
      KIND_OPEN: begin
        if (!door_q) bnd = add(bnd, ACT_OPEN, CH_NONE, 1'b0);
        door_d = 1'b1;
      end
      KIND_LOCK: begin
        bnd    = add(bnd, ACT_LOCK, CH_NONE, 1'b0);
        door_d = 1'b0;
      end
      default: begin
        bnd = '0;
      end
    endcase
    bnd.ccw  = ccw_d;
    bnd.deg  = angle_d;
    bnd.door = door_d;
  end

  assign q_push_o = accept && (bnd.cnt != '0);
  assign q_data_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_WAIT;
      kc_q     <= 4'd0;
      stored_q <= RESET_CODE;
      angle_q  <= RESET_ANGLE;
      ccw_q    <= 1'b0;
      door_q   <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      kc_q     <= kc_d;
      stored_q <= stored_d;
      angle_q  <= angle_d;
      ccw_q    <= ccw_d;
      door_q   <= door_d;
    end
  end

  // Entry buffers need no reset: every entry is written before it is read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q <= ent_d;
      ad_q  <= ad_d;
    end
  end

  `KLC_ASSERT_NEXT(a_lock_closes, accept && kind_i == KIND_LOCK, !door_q, "lock left door open")
  `KLC_ASSERT(a_angle_range, angle_q <= MAX_ANGLE[8:0], "swing angle beyond range")

endmodule

`default_nettype wire

// ===== design/klc_queue.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock controller - bundle queue
// Short first-in first-out store of action bundles between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keypad_code_lock_controller_assert.svh"

module klc_queue import klc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_i,
  input  wire bundle_t wr_data_i,
  output logic         full_o,
  output logic         rd_valid_o,
  output bundle_t      rd_data_o,
  input  wire logic    rd_i
);

  bundle_t          mem_q [QueueDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0]   cnt_q;

  function automatic logic [QPtrW-1:0] inc(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  assign full_o     = (cnt_q == (QPtrW+1)'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= inc(wp_q);
      if (rd_i) rp_q <= inc(rp_q);
      cnt_q <= cnt_q + (QPtrW+1)'(wr_i) - (QPtrW+1)'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_data_i;
  end

  `KLC_ASSERT(a_no_overflow, wr_i |-> !full_o, "bundle written into full queue")
  `KLC_ASSERT(a_no_underflow, rd_i |-> rd_valid_o, "bundle read from empty queue")

endmodule

`default_nettype wire

// ===== design/klc_back.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock controller - back end
// Unpacks the head bundle one action a cycle into the result register, while
// that register is empty or being popped.
`default_nettype none
`include "keypad_code_lock_controller_assert.svh"

module klc_back import klc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire bundle_t q_data_i,
  output logic         q_pop_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output word_t        word_o
);

  logic [SlotW-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  word_t            word_q, word_d;
  logic             load, last, servo;
  slot_t            cur;

  assign load  = q_valid_i && (!out_valid_q || pop_i);
  assign cur   = q_data_i.slot[idx_q];
  assign last  = (idx_q == q_data_i.cnt - SlotW'(1));
  assign servo = (cur.act == ACT_OPEN) || (cur.act == ACT_LOCK);

  always_comb begin
    word_d.act  = cur.act;
    word_d.ch   = cur.ch;
    word_d.msg  = cur.msg;
    word_d.dir  = servo ? q_data_i.ccw : 1'b0;
    word_d.deg  = servo ? q_data_i.deg : 9'd0;
    word_d.door = q_data_i.door;
    word_d.last = last;
    idx_d       = idx_q;
    q_pop_o     = 1'b0;
    if (load) begin
      // advance through the bundle, drop it after its final action
      if (last) begin
        idx_d   = '0;
        q_pop_o = 1'b1;
      end else begin
        idx_d = idx_q + SlotW'(1);
      end
    end
    priority if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) word_q <= word_d;
  end

  assign empty_o = !out_valid_q;
  assign word_o  = word_q;

  `KLC_ASSERT(a_bundle_nonempty, q_valid_i |-> q_data_i.cnt != '0, "empty bundle queued")
  `KLC_ASSERT(a_idx_inside, idx_q != '0 |-> q_valid_i && idx_q < q_data_i.cnt, "slot index lost")

endmodule

`default_nettype wire

// ===== design/keypad_code_lock_controller.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock controller
// Takes key and button events and returns display and servo actions.
// ----------------------------------------------------------------------------
// Each event word (a key press or an open or lock button press) is accepted
// whenever full is low; the front end updates the lock state in that cycle
// and packs the zero to five actions the event causes into one bundle.
// A two-bundle queue parts it from the back end, which hands out one result
// word per cycle while pop is held high, through a registered output; events
// that cause no action never reach the queue. Events can arrive back to back
// while earlier bundles are still being unpacked; full rises only when both
// queue slots hold bundles. Reset value of the stored code is "1234", of the
// swing angle 135 degrees, clockwise, door locked.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_lock_controller import klc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] key_char_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      action_o,
  output logic [7:0]      char_code_o,
  output logic            message_id_o,
  output logic            turn_direction_o,
  output logic [8:0]      turn_degrees_o,
  output logic            door_open_o,
  output logic            last_o
);

  logic    q_push, q_full, q_valid, q_pop;
  bundle_t q_wdata, q_rdata;
  word_t   word;

  // Front end: classify the event and advance the lock state
  klc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .kind_i     (kind_i),
    .key_char_i (key_char_i),
    .full_i     (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // Hold bundles so either side can stall on its own
  klc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_push),
    .wr_data_i  (q_wdata),
    .full_o     (q_full),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_rdata),
    .rd_i       (q_pop)
  );

  // Back end: one action word a cycle while the receiver pops
  klc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .word_o    (word)
  );

  assign full             = q_full;
  assign action_o         = word.act;
  assign char_code_o      = word.ch;
  assign message_id_o     = word.msg;
  assign turn_direction_o = word.dir;
  assign turn_degrees_o   = word.deg;
  assign door_open_o      = word.door;
  assign last_o           = word.last;

endmodule

`default_nettype wire

// ===== dv/keypad_code_lock_controller_tb.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock controller - testbench
// Drives key and button words into the event queue and checks every display
// and servo word against a cycle-free predictor of the lock, with random gaps
// on both sides and one long receiver stall that backs the input up.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_lock_controller_tb;
  import klc_pkg::*;

  // Kind code that the block ignores
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int PLAN_LEN    = 26;      // directed rows
  localparam int FED_WANTED  = 250;     // directed plus random words other than spare kinds and empty keys
  localparam int SQUEEZE_AT  = 100;     // start the long receiver stall here
  localparam int SQUEEZE_LEN = 150;
  localparam int DRAIN       = 50;
  localparam int LIMIT       = 400000;
  localparam int SHOW_MAX    = 40;

  typedef enum logic [2:0] {
    LM_IDLE,
    LM_CODE,
    LM_CHANGE,
    LM_ANGLE,
    LM_DIR
  } lock_mode_e;

  // One input word, with an optional typed-in check on its final result word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key;
    logic       golden;
    action_e    gact;
    logic       gdoor;
  } stim_row_t;

  // One awaited result word
  typedef struct packed {
    word_t   w;
    logic    golden;
    action_e gact;
    logic    gdoor;
  } awaited_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       push       = 1'b0;
  logic [1:0] kind_i     = KIND_KEY;
  logic [7:0] key_char_i = CH_NONE;
  logic       pop        = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] action_o;
  logic [7:0] char_code_o;
  logic       message_id_o;
  logic       turn_direction_o;
  logic [8:0] turn_degrees_o;
  logic       door_open_o;
  logic       last_o;

  keypad_code_lock_controller u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .key_char_i       (key_char_i),
    .empty            (empty),
    .pop              (pop),
    .action_o         (action_o),
    .char_code_o      (char_code_o),
    .message_id_o     (message_id_o),
    .turn_direction_o (turn_direction_o),
    .turn_degrees_o   (turn_degrees_o),
    .door_open_o      (door_open_o),
    .last_o           (last_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Lock predictor state, held at its reset values from time zero
  // --------------------------------------------------------------------------
  lock_mode_e lk_mode       = LM_IDLE;
  logic [3:0] lk_count      = 4'd0;
  logic [7:0] typed_code [4] = '{8'd0, 8'd0, 8'd0, 8'd0};
  logic [7:0] code_store [4] = '{"1", "2", "3", "4"};
  logic [7:0] angle_keys [2] = '{8'd0, 8'd0};
  logic [8:0] swing_deg     = RESET_ANGLE;
  logic       ccw           = 1'b0;
  logic       door          = 1'b0;

  word_t      event_words [$];   // words of the event being predicted
  awaited_t   awaited [$];       // words still owed by the block

  int         fail_count    = 0;
  int         fed_count     = 0;
  int         cycle_count   = 0;
  bit         stim_done     = 1'b0;
  bit         squeezing     = 1'b0;
  bit         squeeze_done  = 1'b0;

  // --------------------------------------------------------------------------
  // Directed plan: buttons and ignored words first, then a code that opens
  // the door, a rejected angle, a direction change and a lock with the new
  // direction. Only rows whose final word is obvious carry a typed-in check.
  // --------------------------------------------------------------------------
  stim_row_t plan [0:PLAN_LEN-1] = '{
    '{KIND_SPARE, 8'hFF,   1'b0, ACT_WRITE,   1'b0},  // unknown kind: nothing
    '{KIND_KEY,   CH_NONE, 1'b0, ACT_WRITE,   1'b0},  // no key: nothing
    '{KIND_OPEN,  CH_NONE, 1'b1, ACT_OPEN,    1'b1},
    '{KIND_OPEN,  8'hFF,   1'b0, ACT_WRITE,   1'b0},  // already open: nothing
    '{KIND_LOCK,  CH_NONE, 1'b1, ACT_LOCK,    1'b0},
    '{KIND_KEY,   "1",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "2",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "3",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "4",     1'b1, ACT_CLEAR,   1'b1},  // reset code opens
    '{KIND_KEY,   CH_HASH, 1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "1",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "2",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "3",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "4",     1'b1, ACT_WRITE,   1'b1},  // echo of '#'
    '{KIND_KEY,   CH_D,    1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "2",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "6",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "1",     1'b1, ACT_CLEAR,   1'b1},  // 261 is over the top
    '{KIND_KEY,   CH_HASH, 1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "1",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "2",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "3",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   "4",     1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   CH_C,    1'b0, ACT_WRITE,   1'b0},
    '{KIND_KEY,   CH_TWO,  1'b1, ACT_MESSAGE, 1'b1},  // counterclockwise
    '{KIND_LOCK,  CH_NONE, 1'b1, ACT_LOCK,    1'b0}
  };

  int        plan_idx = 0;
  stim_row_t pending [$];        // random words queued for the sender

  // --------------------------------------------------------------------------
  // Mismatch reporting: print the first few, count them all
  // --------------------------------------------------------------------------
  task automatic flag(input string what);
    fail_count++;
    if (fail_count <= SHOW_MAX) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [8:0] got,
                             input logic [8:0] want);
    if (got !== want) flag($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit code_ok();
    for (int i = 0; i < 4; i++)
      if (typed_code[i] != code_store[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Append one action; servo words carry the angle and direction of the moment
  task automatic add_word(input action_e act, input logic [7:0] ch, input logic msg);
    word_t w;
    if (event_words.size() >= MaxSlots) return;
    w      = '0;
    w.act  = act;
    w.ch   = (act == ACT_WRITE) ? ch : CH_NONE;
    w.msg  = (act == ACT_MESSAGE) ? msg : 1'b0;
    w.dir  = (act == ACT_OPEN || act == ACT_LOCK) ? ccw : 1'b0;
    w.deg  = (act == ACT_OPEN || act == ACT_LOCK) ? swing_deg : 9'd0;
    event_words.push_back(w);
  endtask

  task automatic press_key(input logic [7:0] key);
    int h, t, u, v;
    bit ok;
    case (lk_mode)
      LM_CODE: begin
        lk_count = lk_count + 4'd1;
        add_word(ACT_WRITE, CH_STAR, 1'b0);
        if (lk_count < 4) typed_code[lk_count] = key;
        if (lk_count >= 3) begin
          if (code_ok()) begin
            if (!door) add_word(ACT_OPEN, CH_NONE, 1'b0);
            door = 1'b1;
          end
          add_word(ACT_CLEAR, CH_NONE, 1'b0);
          lk_count = 4'd0;
          lk_mode  = LM_IDLE;
        end
      end
      LM_CHANGE: begin
        add_word(ACT_WRITE, key, 1'b0);
        if (lk_count < 4) typed_code[lk_count] = key;
        lk_count = lk_count + 4'd1;
        if (lk_count == 4) begin
          if (code_ok()) begin
            add_word(ACT_WRITE, CH_HASH, 1'b0);
          end else begin
            lk_count = 4'd0;
            lk_mode  = LM_IDLE;
            add_word(ACT_CLEAR, CH_NONE, 1'b0);
          end
        end
        // Keys past the old code overwrite the stored code, except a leading
        // 'D' or 'C', which branches off to the angle or direction entry
        if (lk_count == 5 && key != CH_D && key != CH_C) code_store[0] = key;
        if (lk_count >= 6 && lk_count <= 8) code_store[int'(lk_count) - 5] = key;
        if (lk_count == 5 && key == CH_D) lk_mode = LM_ANGLE;
        if (lk_count == 5 && key == CH_C) lk_mode = LM_DIR;
        if (lk_count >= 8) begin
          lk_count = 4'd0;
          lk_mode  = LM_IDLE;
          add_word(ACT_CLEAR, CH_NONE, 1'b0);
        end
      end
      LM_DIR: begin
        add_word(ACT_CLEAR, CH_NONE, 1'b0);
        if (key == CH_ONE) begin
          ccw = 1'b0;
          add_word(ACT_MESSAGE, CH_NONE, 1'b0);
        end else if (key == CH_TWO) begin
          ccw = 1'b1;
          add_word(ACT_MESSAGE, CH_NONE, 1'b1);
        end
        lk_count = 4'd0;
        lk_mode  = LM_IDLE;
      end
      LM_ANGLE: begin
        add_word(ACT_WRITE, key, 1'b0);
        lk_count = lk_count + 4'd1;
        if (lk_count == 6) begin
          angle_keys[0] = key;
        end else if (lk_count == 7) begin
          angle_keys[1] = key;
        end else if (lk_count >= 8) begin
          h  = angle_keys[0];
          t  = angle_keys[1];
          u  = key;
          ok = is_digit(angle_keys[0]) && is_digit(angle_keys[1]) && is_digit(key);
          v  = (h - CH_ZERO) * 100 + (t - CH_ZERO) * 10 + (u - CH_ZERO);
          if (ok && v > MAX_ANGLE) ok = 1'b0;
          add_word(ACT_CLEAR, CH_NONE, 1'b0);
          if (ok) begin
            swing_deg = v[8:0];
            add_word(ACT_WRITE, angle_keys[0], 1'b0);
            add_word(ACT_WRITE, angle_keys[1], 1'b0);
            add_word(ACT_WRITE, key, 1'b0);
          end
          lk_count = 4'd0;
          lk_mode  = LM_IDLE;
        end
      end
      default: begin
        if (lk_count == 0) add_word(ACT_CLEAR, CH_NONE, 1'b0);
        if (key == CH_HASH) begin
          lk_mode = LM_CHANGE;
          add_word(ACT_WRITE, CH_HASH, 1'b0);
        end else begin
          if (lk_count < 4) typed_code[lk_count] = key;
          add_word(ACT_WRITE, CH_STAR, 1'b0);
          lk_mode = LM_CODE;
        end
      end
    endcase
  endtask

  // Work out the words of one accepted event and queue them up
  task automatic predict_event(input stim_row_t ev);
    awaited_t rec;
    int n;
    event_words.delete();
    case (ev.kind)
      KIND_KEY:  if (ev.key != CH_NONE) press_key(ev.key);
      KIND_OPEN: begin
        if (!door) add_word(ACT_OPEN, CH_NONE, 1'b0);
        door = 1'b1;
      end
      KIND_LOCK: begin
        add_word(ACT_LOCK, CH_NONE, 1'b0);
        door = 1'b0;
      end
      default: ;
    endcase
    n = event_words.size();
    for (int i = 0; i < n; i++) begin
      rec        = '0;
      rec.w      = event_words[i];
      rec.w.door = door;
      rec.w.last = (i == n - 1);
      // The typed-in check rides on the final word only
      rec.golden = ev.golden && (i == n - 1);
      rec.gact   = ev.gact;
      rec.gdoor  = ev.gdoor;
      awaited.push_back(rec);
    end
  endtask

  // --------------------------------------------------------------------------
  // Random stimulus: mostly well-formed key sequences built on the current
  // stored code, the rest stray words and sequences cut short.
  // --------------------------------------------------------------------------
  function automatic stim_row_t make_word(input logic [1:0] kind, input logic [7:0] key);
    stim_row_t r;
    r      = '0;
    r.kind = kind;
    r.key  = key;
    return r;
  endfunction

  // Any real key, leaning on the all-ones and lowest codes
  function automatic logic [7:0] rand_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'hFF;
    if (r < 20) return 8'h01;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic enter_admin();
    pending.push_back(make_word(KIND_KEY, CH_HASH));
    for (int i = 0; i < 4; i++) pending.push_back(make_word(KIND_KEY, code_store[i]));
  endtask

  task automatic plan_sequence();
    int pick, v, sel;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // correct code, sometimes from a freshly locked door
      if ($urandom_range(0, 2) == 0) pending.push_back(make_word(KIND_LOCK, CH_NONE));
      for (int i = 0; i < 4; i++) pending.push_back(make_word(KIND_KEY, code_store[i]));
    end else if (pick < 33) begin
      for (int i = 0; i < 4; i++) pending.push_back(make_word(KIND_KEY, rand_key()));
    end else if (pick < 48) begin
      enter_admin();
      for (int i = 0; i < 4; i++) pending.push_back(make_word(KIND_KEY, rand_key()));
    end else if (pick < 63) begin
      enter_admin();
      pending.push_back(make_word(KIND_KEY, CH_D));
      if ($urandom_range(0, 3) == 0) begin
        // digits mixed with other keys
        for (int i = 0; i < 3; i++)
          pending.push_back(make_word(KIND_KEY, $urandom_range(0, 1) ?
                                      8'(CH_ZERO + $urandom_range(0, 9)) : rand_key()));
      end else begin
        sel = $urandom_range(0, 9);
        v   = (sel == 0) ? 260 : (sel == 1) ? 261 : (sel == 2) ? 0 : $urandom_range(0, 299);
        pending.push_back(make_word(KIND_KEY, 8'(CH_ZERO + v / 100)));
        pending.push_back(make_word(KIND_KEY, 8'(CH_ZERO + (v / 10) % 10)));
        pending.push_back(make_word(KIND_KEY, 8'(CH_ZERO + v % 10)));
      end
    end else if (pick < 75) begin
      enter_admin();
      pending.push_back(make_word(KIND_KEY, CH_C));
      sel = $urandom_range(0, 4);
      pending.push_back(make_word(KIND_KEY, (sel < 2) ? CH_ONE : (sel < 4) ? CH_TWO : rand_key()));
    end else if (pick < 85) begin
      pending.push_back(make_word($urandom_range(0, 1) ? KIND_OPEN : KIND_LOCK,
                                  8'($urandom_range(0, 255))));
    end else if (pick < 93) begin
      for (int i = 0; i < $urandom_range(1, 3); i++)
        pending.push_back(make_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
    end else begin
      // change entry abandoned half way
      pending.push_back(make_word(KIND_KEY, CH_HASH));
      pending.push_back(make_word(KIND_KEY, rand_key()));
      pending.push_back(make_word(KIND_KEY, rand_key()));
      pending.push_back(make_word(KIND_LOCK, CH_NONE));
    end
  endtask

  // Gap length: none in calm windows, else mostly short and a few long
  function automatic int draw_gap();
    int r;
    if (cycle_count[9:8] == 2'd0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: predict on every accepted word, then offer the next one
  // --------------------------------------------------------------------------
  stim_row_t offered  = '0;
  int        gap_left = 0;

  always @(posedge clk_i) begin
    bit have;
    stim_row_t nxt;
    if (rst_ni && !stim_done) begin
      if (push && !full) begin
        predict_event(offered);
        if (offered.kind != KIND_SPARE && !(offered.kind == KIND_KEY && offered.key == CH_NONE))
          fed_count++;
      end
      // Hold the word while the block is full
      if (!(push && full)) begin
        have = 1'b0;
        if (gap_left == 0) begin
          if (plan_idx < PLAN_LEN) begin
            nxt  = plan[plan_idx];
            plan_idx++;
            have = 1'b1;
          end else begin
            if (pending.size() == 0 && fed_count < FED_WANTED) plan_sequence();
            if (pending.size() != 0) begin
              nxt  = pending.pop_front();
              have = 1'b1;
            end
          end
        end
        if (gap_left > 0) begin
          push <= 1'b0;
          gap_left--;
        end else if (have) begin
          offered    = nxt;
          push       <= 1'b1;
          kind_i     <= nxt.kind;
          key_char_i <= nxt.key;
          // keep offering back to back while the receiver is held off
          gap_left   = squeezing ? 0 : draw_gap();
        end else begin
          push      <= 1'b0;
          stim_done = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: check each popped word against the oldest awaited one
  // --------------------------------------------------------------------------
  int stall_left   = 0;
  int squeeze_left = 0;

  always @(posedge clk_i) begin
    awaited_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (awaited.size() == 0) begin
          flag($sformatf("word with nothing awaited, action %0d", action_o));
        end else begin
          e = awaited.pop_front();
          check_field("action",         action_o,         e.w.act);
          check_field("char_code",      char_code_o,      e.w.ch);
          check_field("message_id",     message_id_o,     e.w.msg);
          check_field("turn_direction", turn_direction_o, e.w.dir);
          check_field("turn_degrees",   turn_degrees_o,   e.w.deg);
          check_field("door_open",      door_open_o,      e.w.door);
          check_field("last",           last_o,           e.w.last);
          if (e.golden) begin
            check_field("directed action", action_o,    e.gact);
            check_field("directed door",   door_open_o, e.gdoor);
          end
        end
      end
      // Once, hold off long enough for the block to fill and stall its input
      if (!squeeze_done && !squeezing && fed_count >= SQUEEZE_AT) begin
        squeezing    = 1'b1;
        squeeze_left = SQUEEZE_LEN;
      end
      if (squeezing) begin
        pop <= 1'b0;
        squeeze_left--;
        if (squeeze_left == 0) begin
          squeezing    = 1'b0;
          squeeze_done = 1'b1;
        end
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = draw_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Reset, then wait for the stimulus to run out and the block to drain
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!stim_done) @(posedge clk_i);
    while (awaited.size() != 0) @(posedge clk_i);
    // leave room for any stray word to show up
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/klc_pkg.sv
design/klc_front.sv
design/klc_queue.sv
design/klc_back.sv
design/keypad_code_lock_controller.sv
dv/keypad_code_lock_controller_tb.sv
